@@ hw/rtl/gin_pkg.sv @@
// Shared types, codes and constants for the grid index and neighbor core.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package gin_pkg;

  // Number of dimensions the hardware carries registers for.
  localparam int HW_DIMS = 4;
  // Largest dimension count that is honored; larger settings saturate.
  localparam int MAX_DIMS = 4;
  localparam int DIMS_CAP = (MAX_DIMS < HW_DIMS) ? MAX_DIMS : HW_DIMS;
  // Entries in the queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Operation codes carried on s_tuser.
  localparam logic [1:0] FUNC_C2I = 2'd0;
  localparam logic [1:0] FUNC_I2C = 2'd1;
  localparam logic [1:0] FUNC_NBR = 2'd2;
  localparam logic [1:0] FUNC_BAD = 2'd3;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_NUM_DIMS = 3'd0;
  localparam logic [2:0] REG_SIZE0    = 3'd1;
  localparam logic [2:0] REG_SIZE1    = 3'd2;
  localparam logic [2:0] REG_SIZE2    = 3'd3;
  localparam logic [2:0] REG_SIZE3    = 3'd4;

  // Bit positions of the flags on m_tuser.
  localparam int USER_PRESENT = 0;
  localparam int USER_OOR     = 1;

  // Effective grid configuration handed to front and back.
  typedef struct packed {
    logic [2:0]                n;       // dimensions in use, 1..DIMS_CAP
    logic [HW_DIMS-1:0][7:0]   size;    // sizes with zero read as one
    logic [HW_DIMS-1:0][31:0]  stride;  // index step per dimension
    logic [31:0]               total;   // cell count over the dimensions in use
  } cfg_t;

  // One classified item waiting in the queue.
  typedef struct packed {
    logic [1:0]                func;
    logic                      err;
    logic [31:0]               idx;
    logic [HW_DIMS-1:0][7:0]   coord;
  } cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/gin_cfg.sv @@
// Configuration registers with APB-style access and the stride sequencer.
// Depends on gin_pkg.
`default_nettype none

module gin_cfg
  import gin_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg,
  output logic             busy
);

  logic [2:0]               num_dims;
  logic [HW_DIMS-1:0][7:0]  size_raw;
  logic [HW_DIMS-1:0][7:0]  size_e;
  logic [HW_DIMS-1:0][31:0] prod;
  logic [1:0]               step;
  logic                     wr;
  logic [2:0]               reg_idx;
  logic [2:0]               n_eff;
  logic [2:0]               n_m1;
  logic [39:0]              prod_wide;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims <= 3'd2;
      size_raw <= {8'd1, 8'd1, 8'd16, 8'd16};
    end else if (wr) begin
      unique case (reg_idx)
        REG_NUM_DIMS: num_dims    <= pwdata[2:0];
        REG_SIZE0:    size_raw[0] <= pwdata[7:0];
        REG_SIZE1:    size_raw[1] <= pwdata[7:0];
        REG_SIZE2:    size_raw[2] <= pwdata[7:0];
        REG_SIZE3:    size_raw[3] <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads.
  always_comb begin
    unique case (reg_idx)
      REG_NUM_DIMS: prdata = {29'd0, num_dims};
      REG_SIZE0:    prdata = {24'd0, size_raw[0]};
      REG_SIZE1:    prdata = {24'd0, size_raw[1]};
      REG_SIZE2:    prdata = {24'd0, size_raw[2]};
      REG_SIZE3:    prdata = {24'd0, size_raw[3]};
      default:      prdata = 32'd0;
    endcase
  end

  // Effective sizes and dimension count.
  always_comb begin
    for (int d = 0; d < HW_DIMS; d++) begin
      size_e[d] = (size_raw[d] == 8'd0) ? 8'd1 : size_raw[d];
    end
    if (num_dims == 3'd0) begin
      n_eff = 3'd1;
    end else if (num_dims > 3'(DIMS_CAP)) begin
      n_eff = 3'(DIMS_CAP);
    end else begin
      n_eff = num_dims;
    end
  end

  // Running products of the sizes, one multiplication per cycle after a write.
  assign prod_wide = prod[step - 2'd1] * size_e[step];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= 2'd0;
      prod <= {32'd256, 32'd256, 32'd256, 32'd16};
    end else if (wr) begin
      busy <= 1'b1;
      step <= 2'd0;
    end else if (busy) begin
      if (step == 2'd0) begin
        prod[0] <= {24'd0, size_e[0]};
      end else begin
        prod[step] <= prod_wide[31:0];
      end
      step <= step + 2'd1;
      if (step == 2'(HW_DIMS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign n_m1 = n_eff - 3'd1;

  // Strides and cell count as seen by the datapath.
  always_comb begin
    cfg.n    = n_eff;
    cfg.size = size_e;
    cfg.stride[0] = 32'd1;
    for (int d = 1; d < HW_DIMS; d++) begin
      cfg.stride[d] = prod[d - 1];
    end
    cfg.total = prod[n_m1[1:0]];
  end

endmodule

`default_nettype wire

@@ hw/rtl/gin_front.sv @@
// Input side: accepts items and classifies them, flagging out-of-grid input
// and unknown operation codes. Depends on gin_pkg.
`default_nettype none

module gin_front
  import gin_pkg::*;
(
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,
  input  wire logic [1:0]  s_tuser,
  input  cfg_t             cfg,
  input  wire logic        cfg_busy,
  input  wire logic        q_full,
  output logic             push,
  output cmd_t             cmd
);

  logic coord_bad;
  logic idx_bad;

  assign s_tready = !q_full && !cfg_busy;
  assign push     = s_tvalid && s_tready;

  // Range checks on the incoming item.
  always_comb begin
    coord_bad = 1'b0;
    for (int d = 0; d < HW_DIMS; d++) begin
      if ((3'(d) < cfg.n) && (s_tdata[32 + 8*d +: 8] >= cfg.size[d])) begin
        coord_bad = 1'b1;
      end
    end
    idx_bad = s_tdata[31:0] >= cfg.total;
  end

  // Classified command for the back end.
  always_comb begin
    cmd.func  = s_tuser;
    cmd.idx   = s_tdata[31:0];
    cmd.coord = s_tdata[63:32];
    unique case (s_tuser) inside
      FUNC_C2I:           cmd.err = coord_bad;
      FUNC_I2C, FUNC_NBR: cmd.err = idx_bad;
      default:            cmd.err = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/gin_queue.sv @@
// Short queue of classified commands between front and back.
// Depends on gin_pkg.
`default_nettype none

module gin_queue
  import gin_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      din,
  output logic      full,
  input  wire logic pop,
  output cmd_t      dout,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/gin_back.sv @@
// Execution side: index arithmetic, serial division, neighbor emission and
// the output register. Depends on gin_pkg.
`default_nettype none

module gin_back
  import gin_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  cfg_t             cfg,
  input  wire logic        q_empty,
  input  cmd_t             q_dout,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // result_index, out_coord_0..3
  output logic [1:0]       m_tuser,   // present, out_of_range
  output logic             m_tlast
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ACC  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                  state;
  cmd_t                    cur;
  logic [1:0]              dim;
  logic [2:0]              bitc;
  logic [7:0]              quo;
  logic [31:0]             rem;
  logic [31:0]             acc;
  logic [HW_DIMS-1:0][7:0] crd;
  logic [2:0]              k;

  logic [2:0]  n_m1;
  logic [39:0] trial;
  logic        ge;
  logic [7:0]  quo_next;
  logic [39:0] mac;
  logic        out_free;
  logic        emit;
  logic [1:0]  nd;
  logic [3:0]  k_last;
  logic [31:0] r_idx;
  logic [HW_DIMS-1:0][7:0] r_crd;
  logic        r_pres;
  logic        r_oor;
  logic        r_last;

  assign n_m1     = cfg.n - 3'd1;
  assign pop      = (state == S_IDLE) && !q_empty;
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == S_EMIT) && out_free;

  // One restoring-division step: one quotient bit per cycle.
  assign trial    = {8'd0, cfg.stride[dim]} << bitc;
  assign ge       = {8'd0, rem} >= trial;
  assign quo_next = quo | (ge ? (8'd1 << bitc) : 8'd0);

  // Multiply-accumulate for coordinates to index.
  assign mac = cur.coord[dim] * cfg.stride[dim];

  // Result selection for the current emission.
  assign nd     = k[2:1];
  assign k_last = ({1'b0, cfg.n} << 1) - 4'd1;

  always_comb begin
    r_idx  = 32'd0;
    r_crd  = '0;
    r_pres = 1'b0;
    r_oor  = 1'b0;
    r_last = 1'b1;
    if (cur.err) begin
      r_oor = 1'b1;
    end else begin
      case (cur.func)
        FUNC_C2I: begin
          r_idx  = acc;
          r_pres = 1'b1;
        end
        FUNC_I2C: begin
          r_idx  = cur.idx;
          r_crd  = crd;
          r_pres = 1'b1;
        end
        default: begin
          r_last = ({1'b0, k} == k_last);
          if (!k[0]) begin
            r_pres = (crd[nd] != 8'd0);
            r_idx  = r_pres ? cur.idx - cfg.stride[nd] : 32'd0;
          end else begin
            r_pres = (crd[nd] != cfg.size[nd] - 8'd1);
            r_idx  = r_pres ? cur.idx + cfg.stride[nd] : 32'd0;
          end
        end
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dim   <= 2'd0;
      bitc  <= 3'd7;
      k     <= 3'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            k    <= 3'd0;
            bitc <= 3'd7;
            if (q_dout.err) begin
              state <= S_EMIT;
            end else if (q_dout.func == FUNC_C2I) begin
              dim   <= 2'd0;
              state <= S_ACC;
            end else begin
              dim   <= n_m1[1:0];
              state <= S_DIV;
            end
          end
        end
        S_ACC: begin
          if (dim == n_m1[1:0]) begin
            state <= S_EMIT;
          end else begin
            dim <= dim + 2'd1;
          end
        end
        S_DIV: begin
          bitc <= bitc - 3'd1;
          if (bitc == 3'd0) begin
            if (dim == 2'd0) begin
              state <= S_EMIT;
            end else begin
              dim <= dim - 2'd1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            k <= k + 3'd1;
            if (r_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_dout;
      acc <= 32'd0;
      rem <= q_dout.idx;
      quo <= 8'd0;
      crd <= '0;
    end
    if (state == S_ACC) begin
      acc <= acc + mac[31:0];
    end
    if (state == S_DIV) begin
      if (ge) begin
        rem <= rem - trial[31:0];
      end
      if (bitc == 3'd0) begin
        crd[dim] <= quo_next;
        quo      <= 8'd0;
      end else begin
        quo <= quo_next;
      end
    end
  end

  // Output register: loads when empty or while the previous result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata               <= {r_crd, r_idx};
      m_tuser[USER_PRESENT] <= r_pres;
      m_tuser[USER_OOR]     <= r_oor;
      m_tlast               <= r_last;
    end
  end

  // An error result is always single and never marks a neighbor.
  a_oor_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_OOR] |-> m_tlast && !m_tuser[USER_PRESENT])
    else $error("error result without last or with present");

  // Neighbor emission never runs past the last dimension in use.
  a_k_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) && !cur.err && (cur.func == FUNC_NBR)
      |-> ({1'b0, k} <= k_last))
    else $error("neighbor counter beyond dimension count");

  // A popped command always starts work.
  a_pop_start: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state != S_IDLE))
    else $error("command popped but sequencer idle");

endmodule

`default_nettype wire

@@ hw/rtl/grid_index_and_neighbors_core.sv @@
// Top level of the grid index and neighbor core.
// Depends on gin_pkg, gin_cfg, gin_front, gin_queue and gin_back.
//
// Channel   Direction  Transfer condition              Payload
// s_*       in         s_tvalid & s_tready             tuser func, tdata index+coords
// m_*       out        m_tvalid & m_tready             tuser flags, tdata index+coords
// APB       in         psel & penable & pwrite         num_dims, size_dim0..3
//
// Coordinates to index use one multiply-add per dimension. Index to coordinates
// and neighbors recover each coordinate with the one-bit-per-cycle divider.
// After any register write, the stride sequencer holds s_tready low while it
// recomputes the strides; reset loads the strides directly. A stalled output
// holds the back end; the queue keeps accepting up to two items meanwhile.
`default_nettype none

module grid_index_and_neighbors_core
  import gin_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // cell_index, coord_0, coord_1, coord_2, coord_3
  input  wire logic [1:0]  s_tuser,   // func
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // result_index, out_coord_0..out_coord_3
  output logic [1:0]       m_tuser,   // present, out_of_range
  output logic             m_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t cfg;
  logic cfg_busy;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t cmd_in;
  cmd_t cmd_out;

  gin_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .busy    (cfg_busy)
  );

  gin_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cfg      (cfg),
    .cfg_busy (cfg_busy),
    .q_full   (q_full),
    .push     (push),
    .cmd      (cmd_in)
  );

  gin_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (q_full),
    .pop   (pop),
    .dout  (cmd_out),
    .empty (q_empty)
  );

  gin_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_dout   (cmd_out),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_grid_index_and_neighbors_core.sv @@
// Testbench for grid_index_and_neighbors_core: index/coordinate conversion and neighbor lookup.
// Depends on gin_pkg and the core; stimulus is checked against an in-bench grid predictor.
`default_nettype none

module tb_grid_index_and_neighbors_core;
  import gin_pkg::*;

  typedef struct packed {
    logic [31:0]      idx;
    logic [3:0][7:0]  crd;
    logic             present;
    logic             oor;
    logic             last;
  } grid_result_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] idx;
    logic [7:0]  c0, c1, c2, c3;
    logic        check_typed;
    logic [31:0] typed_idx;
    logic        typed_oor;
  } stim_row_t;

  logic clk, rst;
  logic s_tvalid, s_tready;
  logic [63:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tlast;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  grid_index_and_neighbors_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the grid registers.
  logic [2:0] grid_dims;
  logic [7:0] shadow_size [4];

  grid_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int func_count [4];
  bit sink_calm = 0;
  bit src_calm = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // Predict the results of one input and append them to the expected queue.
  task automatic predict_grid(input logic [1:0] func, input logic [31:0] idx,
                              input logic [7:0] c0, c1, c2, c3);
    int unsigned n, d, k;
    longint unsigned sz [4];
    longint unsigned stride [4];
    longint unsigned total, sum, rem;
    longint unsigned crd [4];
    logic [7:0] cin [4];
    grid_result_t r;
    n = (grid_dims == 0) ? 1 : ((grid_dims > DIMS_CAP) ? DIMS_CAP : grid_dims);
    cin[0] = c0; cin[1] = c1; cin[2] = c2; cin[3] = c3;
    total = 1;
    for (d = 0; d < 4; d++) begin
      sz[d] = (shadow_size[d] == 0) ? 1 : shadow_size[d];
      stride[d] = total;
      if (d < n) total = total * sz[d];
      crd[d] = 0;
    end
    r = '0;
    if (func == FUNC_C2I) begin
      sum = 0;
      for (d = 0; d < n; d++) begin
        if (cin[d] >= sz[d]) begin
          r.oor = 1; r.last = 1;
          pending_results.push_back(r);
          return;
        end
        sum += cin[d] * stride[d];
      end
      r.idx = sum; r.present = 1; r.last = 1;
      pending_results.push_back(r);
      return;
    end
    if (func == FUNC_BAD || idx >= total) begin
      r.oor = 1; r.last = 1;
      pending_results.push_back(r);
      return;
    end
    rem = idx;
    for (k = n; k > 0; k--) begin
      crd[k-1] = rem / stride[k-1];
      rem = rem % stride[k-1];
    end
    if (func == FUNC_I2C) begin
      r.idx = idx; r.present = 1; r.last = 1;
      for (d = 0; d < 4; d++) r.crd[d] = crd[d];
      pending_results.push_back(r);
      return;
    end
    for (d = 0; d < n; d++) begin
      r = '0;
      if (crd[d] != 0) begin r.idx = idx - stride[d]; r.present = 1; end
      pending_results.push_back(r);
      r = '0;
      if (crd[d] != sz[d] - 1) begin r.idx = idx + stride[d]; r.present = 1; end
      r.last = (d + 1 == n);
      pending_results.push_back(r);
    end
  endtask

  // Register write over APB: setup then access phase.
  task automatic write_reg(input logic [2:0] reg_idx, input logic [31:0] value);
    s_tvalid <= 0;
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {reg_idx, 2'b00}; pwdata <= value;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (reg_idx == REG_NUM_DIMS) grid_dims = value[2:0];
    else shadow_size[reg_idx - REG_SIZE0] = value[7:0];
  endtask

  task automatic set_grid(input logic [2:0] n, input logic [7:0] a, b, c, e);
    write_reg(REG_NUM_DIMS, n);
    write_reg(REG_SIZE0, a);
    write_reg(REG_SIZE1, b);
    write_reg(REG_SIZE2, c);
    write_reg(REG_SIZE3, e);
  endtask

  // Let every outstanding result drain, then a quiet margin.
  task automatic drain_results();
    s_tvalid <= 0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  // Send one transfer and record its expected results on acceptance.
  // s_tvalid stays high afterwards so the next item can follow at once; idling,
  // draining and register writes drop it.
  task automatic send_item(input logic [1:0] func, input logic [31:0] idx,
                           input logic [7:0] c0, c1, c2, c3);
    while (!src_calm && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= func;
    s_tdata <= {c3, c2, c1, c0, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_grid(func, idx, c0, c1, c2, c3);
    items_sent++;
    func_count[func]++;
    @(negedge clk);
  endtask

  // Cell count of the current grid, for aiming random indexes.
  function automatic longint unsigned grid_cells();
    int unsigned n, d;
    longint unsigned t;
    n = (grid_dims == 0) ? 1 : ((grid_dims > DIMS_CAP) ? DIMS_CAP : grid_dims);
    t = 1;
    for (d = 0; d < n; d++) t = t * ((shadow_size[d] == 0) ? 1 : shadow_size[d]);
    return t;
  endfunction

  task automatic send_random(input int count);
    int i;
    logic [1:0] func;
    logic [31:0] idx;
    logic [7:0] cc [4];
    longint unsigned cells;
    for (i = 0; i < count; i++) begin
      cells = grid_cells();
      func = $urandom_range(0, 9) == 0 ? FUNC_BAD : $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) idx = $urandom;
      else idx = $urandom_range(0, cells - 1);
      for (int d = 0; d < 4; d++) begin
        if ($urandom_range(0, 9) == 0) cc[d] = $urandom_range(0, 255);
        else cc[d] = $urandom_range(0, ((shadow_size[d] == 0) ? 1 : shadow_size[d]) - 1);
      end
      send_item(func, idx, cc[0], cc[1], cc[2], cc[3]);
    end
  endtask

  // Output side: random back-pressure and comparison against the oldest expectation.
  always @(negedge clk) begin
    if (!rst) m_tready <= sink_calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    grid_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.idx = m_tdata[31:0];
      got.crd = m_tdata[63:32];
      got.present = m_tuser[USER_PRESENT];
      got.oor = m_tuser[USER_OOR];
      got.last = m_tlast;
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: idx %h/%h crd %h/%h pres %b/%b oor %b/%b last %b/%b",
                     want.idx, got.idx, want.crd, got.crd, want.present, got.present,
                     want.oor, got.oor, want.last, got.last);
        end
      end
    end
  end

  stim_row_t rows [$];

  function automatic stim_row_t mk(logic [1:0] f, logic [31:0] i, logic [7:0] a, b, c, e,
                                   logic chk, logic [31:0] ti, logic to);
    stim_row_t s;
    s.func = f; s.idx = i; s.c0 = a; s.c1 = b; s.c2 = c; s.c3 = e;
    s.check_typed = chk; s.typed_idx = ti; s.typed_oor = to;
    return s;
  endfunction

  initial begin
    int phase;
    grid_result_t first;
    rst = 1; s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    grid_dims = 2; shadow_size[0] = 16; shadow_size[1] = 16;
    shadow_size[2] = 1; shadow_size[3] = 1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed rows against the reset grid of 16 by 16.
    rows.push_back(mk(FUNC_C2I, 0, 0, 0, 0, 0, 1, 0, 0));
    rows.push_back(mk(FUNC_C2I, 0, 15, 15, 0, 0, 1, 255, 0));
    rows.push_back(mk(FUNC_C2I, 0, 16, 0, 0, 0, 1, 0, 1));
    rows.push_back(mk(FUNC_C2I, 0, 3, 255, 254, 254, 1, 0, 1));
    rows.push_back(mk(FUNC_C2I, 0, 3, 4, 254, 255, 1, 67, 0));
    rows.push_back(mk(FUNC_I2C, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(FUNC_I2C, 255, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(FUNC_I2C, 256, 0, 0, 0, 0, 1, 0, 1));
    rows.push_back(mk(FUNC_I2C, 32'hFFFF_FFFF, 0, 0, 0, 0, 1, 0, 1));
    rows.push_back(mk(FUNC_NBR, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(FUNC_NBR, 255, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(FUNC_NBR, 100, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk(FUNC_NBR, 256, 0, 0, 0, 0, 1, 0, 1));
    rows.push_back(mk(FUNC_BAD, 5, 1, 1, 1, 1, 1, 0, 1));
    foreach (rows[i]) begin
      send_item(rows[i].func, rows[i].idx, rows[i].c0, rows[i].c1, rows[i].c2, rows[i].c3);
      if (rows[i].check_typed) begin
        first = pending_results[pending_results.size() - 1];
        if (first.idx !== rows[i].typed_idx || first.oor !== rows[i].typed_oor) begin
          mismatches++;
          $display("Directed row %0d predicts %h, table says %h", i, first.idx,
                   rows[i].typed_idx);
        end
      end
    end
    drain_results();

    // Extremes: zero dims and zero sizes read as one; oversized dims saturate.
    set_grid(0, 0, 7, 0, 0);
    send_random(10);
    drain_results();
    set_grid(7, 255, 255, 255, 255);
    send_item(FUNC_I2C, 32'hFC05_FC04, 0, 0, 0, 0);
    send_item(FUNC_NBR, 32'hFC05_FC04, 0, 0, 0, 0);
    send_item(FUNC_NBR, 0, 0, 0, 0, 0);
    send_item(FUNC_C2I, 0, 254, 254, 254, 254);
    send_item(FUNC_I2C, 32'hFC05_FC05, 0, 0, 0, 0);
    send_random(20);
    drain_results();

    // Random phases over varied grids; one phase runs without any idling.
    for (phase = 0; phase < 8; phase++) begin
      if (phase == 0) set_grid(1, 255, 1, 1, 1);
      else if (phase == 1) set_grid(4, 1, 1, 1, 1);
      else if (phase == 2) set_grid(3, 2, 3, 4, 9);
      else set_grid($urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 12),
                    $urandom_range(0, 6), $urandom_range(0, 255));
      src_calm = (phase == 4);
      sink_calm = (phase == 4);
      send_random(53);
      // The sender holds off until everything has come back.
      if (phase == 5) begin
        drain_results();
        send_random(5);
      end
      drain_results();
    end
    src_calm = 0; sink_calm = 0;

    $display("Sent %0d items (c2i %0d, i2c %0d, nbr %0d, bad %0d), checked %0d results.",
             items_sent, func_count[0], func_count[1], func_count[2], func_count[3],
             results_seen);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d missing", mismatches, pending_results.size());
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
